### rtl/core/esd_pkg.sv
// ----------------------------------------------------------------------------
// esd_pkg
// Shared types and constants for the escape sequence decoder.
// ----------------------------------------------------------------------------
package esd_pkg;

    localparam int ESD_CMD_DEPTH = 4;
    localparam int ESD_MAX_BYTES = 3;

    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_X         = 8'h78;
    localparam logic [7:0] CHAR_QUESTION  = 8'h3F;
    localparam logic [7:0] CHAR_ESC       = 8'h1B;

    // One decoded command: up to three result bytes and how many are used.
    typedef struct packed {
        logic [ESD_MAX_BYTES-1:0][7:0] bytes;
        logic [1:0]                    count;
    } esd_cmd_t;

endpackage

### rtl/core/escape_sequence_decoder.sv
// ----------------------------------------------------------------------------
// escape_sequence_decoder
// Removes C-style backslash escapes from a byte stream.
// ----------------------------------------------------------------------------
// Each input transaction carries one byte and is decoded in the cycle it is
// taken; plain bytes, escape letters, and two-digit hex escapes each give at
// most one result, and an end-of-stream byte may add up to three flushed bytes
// of pending escape text. The front decoder takes one byte per cycle whenever
// the command queue (CMD_DEPTH entries) has room, and the output sequencer
// delivers one result per cycle while the receiver pops, so the sustained
// rate is one byte per cycle; an input that yields several results occupies
// the output side for one pop per result, and a full queue then holds off
// input. Results go through the queue and the sequencer's command register.
module escape_sequence_decoder
    import esd_pkg::*;
#(
    parameter int CMD_DEPTH = ESD_CMD_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    input  logic       end_of_stream,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       last_of_run
);

    esd_cmd_t cmd_in;
    esd_cmd_t cmd_out;
    logic     cmd_write;
    logic     cmd_read;
    logic     cmd_empty;
    logic     accept;

    assign accept = push && !full;

    esd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .in_byte       (in_byte),
        .end_of_stream (end_of_stream),
        .cmd_write     (cmd_write),
        .cmd           (cmd_in)
    );

    esd_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .write      (cmd_write),
        .wdata      (cmd_in),
        .read       (cmd_read),
        .rdata      (cmd_out),
        .full       (full),
        .fifo_empty (cmd_empty)
    );

    esd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .fifo_data   (cmd_out),
        .fifo_empty  (cmd_empty),
        .fifo_read   (cmd_read),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .empty       (empty),
        .pop         (pop)
    );

endmodule

### rtl/core/esd_front.sv
// ----------------------------------------------------------------------------
// esd_front
// Accepts raw bytes, tracks the escape state and turns each byte into a
// command of zero to three result bytes.
// ----------------------------------------------------------------------------
module esd_front
    import esd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] in_byte,
    input  logic       end_of_stream,
    output logic       cmd_write,
    output esd_cmd_t   cmd
);

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_ESCAPE = 2'd1;
    localparam logic [1:0] MODE_HEX    = 2'd2;

    logic [1:0] mode_reg;
    logic [1:0] mode_next;
    logic       held_reg;
    logic       held_next;
    logic [7:0] digit_reg;
    logic [7:0] digit_next;

    logic       main_valid;
    logic [7:0] main_byte;
    logic [4:0] hi_val;
    logic [4:0] lo_val;

    // Bit 4 flags a valid digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        begin
            r = 5'd0;
            if (c >= 8'h30 && c <= 8'h39)
            begin
                r = {1'b1, 4'(c - 8'h30)};
            end
            else if (c >= 8'h61 && c <= 8'h66)
            begin
                r = {1'b1, 4'(c - 8'h57)};
            end
            else if (c >= 8'h41 && c <= 8'h46)
            begin
                r = {1'b1, 4'(c - 8'h37)};
            end
            return r;
        end
    endfunction

    function automatic logic [7:0] escape_letter(input logic [7:0] c);
        logic [7:0] r;
        begin
            unique case (c)
                8'h30:   r = 8'h00;
                8'h61:   r = 8'h07;
                8'h62:   r = 8'h08;
                8'h74:   r = 8'h09;
                8'h6E:   r = 8'h0A;
                8'h66:   r = 8'h0C;
                8'h72:   r = 8'h0D;
                8'h65:   r = CHAR_ESC;
                default: r = c;
            endcase
            return r;
        end
    endfunction

    assign hi_val = hex_value(digit_reg);
    assign lo_val = hex_value(in_byte);

    always_comb
    begin
        mode_next  = mode_reg;
        held_next  = held_reg;
        digit_next = digit_reg;
        main_valid = 1'b0;
        main_byte  = in_byte;
        unique case (mode_reg)
            MODE_ESCAPE:
            begin
                if (in_byte == CHAR_X)
                begin
                    mode_next = MODE_HEX;
                    held_next = 1'b0;
                end
                else
                begin
                    main_valid = 1'b1;
                    main_byte  = escape_letter(in_byte);
                    mode_next  = MODE_NORMAL;
                end
            end
            MODE_HEX:
            begin
                if (!held_reg)
                begin
                    digit_next = in_byte;
                    held_next  = 1'b1;
                end
                else
                begin
                    main_valid = 1'b1;
                    main_byte  = (hi_val[4] && lo_val[4]) ? {hi_val[3:0], lo_val[3:0]}
                                                          : CHAR_QUESTION;
                    mode_next  = MODE_NORMAL;
                    held_next  = 1'b0;
                end
            end
            default:
            begin
                if (in_byte == CHAR_BACKSLASH)
                begin
                    mode_next = MODE_ESCAPE;
                end
                else
                begin
                    mode_next  = MODE_NORMAL;
                    main_valid = 1'b1;
                end
            end
        endcase

        // A pending escape never coexists with a byte emitted by this input.
        cmd.bytes = {digit_next, CHAR_X, CHAR_BACKSLASH};
        cmd.count = {1'b0, main_valid};
        if (!end_of_stream || mode_next == MODE_NORMAL)
        begin
            cmd.bytes[0] = main_byte;
        end
        else if (mode_next == MODE_ESCAPE)
        begin
            cmd.count = 2'd1;
        end
        else if (mode_next == MODE_HEX)
        begin
            cmd.count = held_next ? 2'd3 : 2'd2;
        end
        else
        begin
            cmd.bytes[0] = main_byte;
        end
        if (end_of_stream)
        begin
            mode_next = MODE_NORMAL;
            held_next = 1'b0;
        end
    end

    assign cmd_write = accept && (cmd.count != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_NORMAL;
            held_reg  <= 1'b0;
            digit_reg <= 8'h00;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            held_reg  <= held_next;
            digit_reg <= digit_next;
        end
    end

    a_held_only_in_hex: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg |-> mode_reg == MODE_HEX)
        else $error("Digit held outside hex mode.");

    a_mode_legal: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg != 2'd3)
        else $error("Unused decode mode reached.");

    a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && end_of_stream |=> mode_reg == MODE_NORMAL && !held_reg)
        else $error("State not cleared after end of stream.");

endmodule

### rtl/core/esd_cmd_fifo.sv
// ----------------------------------------------------------------------------
// esd_cmd_fifo
// Short command queue between the decoding front and the output sequencer.
// ----------------------------------------------------------------------------
module esd_cmd_fifo
    import esd_pkg::*;
#(
    parameter int DEPTH = ESD_CMD_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     write,
    input  esd_cmd_t wdata,
    input  logic     read,
    output esd_cmd_t rdata,
    output logic     full,
    output logic     fifo_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    esd_cmd_t         slots_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg;
    logic [PTR_W-1:0] rptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full       = (count_reg == FULL_CNT);
    assign fifo_empty = (count_reg == '0);
    assign rdata      = slots_reg[rptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (write && !read)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (read && !write)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (write)
        begin
            slots_reg[wptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (write)
            begin
                wptr_reg <= (wptr_reg == LAST_PTR) ? '0 : wptr_reg + 1'b1;
            end
            if (read)
            begin
                rptr_reg <= (rptr_reg == LAST_PTR) ? '0 : rptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        write |-> !full)
        else $error("Command written into a full queue.");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        read |-> !fifo_empty)
        else $error("Command read from an empty queue.");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("Queue count out of range.");

endmodule

### rtl/core/esd_back.sv
// ----------------------------------------------------------------------------
// esd_back
// Output sequencer: holds one command and presents its bytes one transaction
// at a time, loading the next command when idle or as the last byte leaves.
// ----------------------------------------------------------------------------
module esd_back
    import esd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  esd_cmd_t   fifo_data,
    input  logic       fifo_empty,
    output logic       fifo_read,
    output logic [7:0] out_byte,
    output logic       last_of_run,
    output logic       empty,
    input  logic       pop
);

    esd_cmd_t   cmd_reg;
    logic       busy_reg;
    logic [1:0] idx_reg;
    logic       take;
    logic       finishing;

    assign empty       = !busy_reg;
    assign last_of_run = (idx_reg == cmd_reg.count - 2'd1);
    assign take        = pop && busy_reg;
    assign finishing   = take && last_of_run;
    assign fifo_read   = !fifo_empty && (!busy_reg || finishing);

    always_comb
    begin
        case (idx_reg)
            2'd0:    out_byte = cmd_reg.bytes[0];
            2'd1:    out_byte = cmd_reg.bytes[1];
            default: out_byte = cmd_reg.bytes[2];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (fifo_read)
        begin
            cmd_reg <= fifo_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end
        else if (fifo_read)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= 2'd0;
        end
        else if (finishing)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end
        else if (take)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> idx_reg < cmd_reg.count)
        else $error("Output index past the end of the command.");

    a_no_empty_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_read |=> cmd_reg.count != 2'd0)
        else $error("Command with no bytes loaded.");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !pop |=> busy_reg && $stable(idx_reg))
        else $error("Waiting result changed without a transaction.");

endmodule

### sim/unescape_tb_pkg.sv
// ----------------------------------------------------------------------------
// unescape_tb_pkg
// Expected-output tracking for the escape sequence decoder testbench.
// ----------------------------------------------------------------------------
// The checker keeps its own copy of the decoder state. From every accepted
// input transaction it works out the decoded bytes, and it compares each
// accepted output transaction with the oldest decoded byte still waiting.
// ----------------------------------------------------------------------------
package unescape_tb_pkg;

    import esd_pkg::*;

    typedef enum logic [1:0] {
        MODE_PLAIN   = 2'd0,
        MODE_ESCAPED = 2'd1,
        MODE_HEX     = 2'd2
    } unescape_mode_e;

    localparam logic [4:0] HEX_INVALID = 5'd16;
    localparam int unsigned MISMATCH_PRINT_LIMIT = 10;

    class unescape_checker;
        unescape_mode_e mode;
        bit             digit_held;
        logic [7:0]     first_digit;
        logic [7:0]     want_byte[$];
        bit             want_last[$];
        int unsigned    bytes_in;
        int unsigned    bytes_out;
        int unsigned    flushes;
        int unsigned    mismatches;

        function new();
            mode        = MODE_PLAIN;
            digit_held  = 1'b0;
            first_digit = '0;
            bytes_in    = 0;
            bytes_out   = 0;
            flushes     = 0;
            mismatches  = 0;
        endfunction

        function logic [7:0] escape_letter(logic [7:0] c);
            case (c)
                "0":     return 8'h00;
                "a":     return 8'h07;
                "b":     return 8'h08;
                "t":     return 8'h09;
                "n":     return 8'h0A;
                "f":     return 8'h0C;
                "r":     return 8'h0D;
                "e":     return CHAR_ESC;
                default: return c;
            endcase
        endfunction

        function logic [4:0] hex_value(logic [7:0] c);
            if (c >= "0" && c <= "9")
            begin
                return 5'(c - "0");
            end
            if (c >= "a" && c <= "f")
            begin
                return 5'(c - "a" + 8'd10);
            end
            if (c >= "A" && c <= "F")
            begin
                return 5'(c - "A" + 8'd10);
            end
            return HEX_INVALID;
        endfunction

        function void queue_decoded(logic [7:0] value);
            want_byte.push_back(value);
            want_last.push_back(1'b0);
        endfunction

        function void note_failure(string msg);
            mismatches++;
            if (mismatches <= MISMATCH_PRINT_LIMIT)
            begin
                $display("MISMATCH %s", msg);
            end
        endfunction

        function void note_raw_byte(logic [7:0] c, logic eos);
            int unsigned first_new;
            logic [4:0]  hi;
            logic [4:0]  lo;
            first_new = want_byte.size();
            bytes_in++;
            case (mode)
                MODE_ESCAPED:
                begin
                    if (c == CHAR_X)
                    begin
                        mode       = MODE_HEX;
                        digit_held = 1'b0;
                    end
                    else
                    begin
                        queue_decoded(escape_letter(c));
                        mode = MODE_PLAIN;
                    end
                end
                MODE_HEX:
                begin
                    if (!digit_held)
                    begin
                        first_digit = c;
                        digit_held  = 1'b1;
                    end
                    else
                    begin
                        hi = hex_value(first_digit);
                        lo = hex_value(c);
                        if (hi != HEX_INVALID && lo != HEX_INVALID)
                        begin
                            queue_decoded({hi[3:0], lo[3:0]});
                        end
                        else
                        begin
                            queue_decoded(CHAR_QUESTION);
                        end
                        mode       = MODE_PLAIN;
                        digit_held = 1'b0;
                    end
                end
                default:
                begin
                    mode = MODE_PLAIN;
                    if (c == CHAR_BACKSLASH)
                    begin
                        mode = MODE_ESCAPED;
                    end
                    else
                    begin
                        queue_decoded(c);
                    end
                end
            endcase
            if (eos)
            begin
                if (mode != MODE_PLAIN)
                begin
                    flushes++;
                end
                if (mode == MODE_ESCAPED)
                begin
                    queue_decoded(CHAR_BACKSLASH);
                end
                else if (mode == MODE_HEX)
                begin
                    queue_decoded(CHAR_BACKSLASH);
                    queue_decoded(CHAR_X);
                    if (digit_held)
                    begin
                        queue_decoded(first_digit);
                    end
                end
                mode       = MODE_PLAIN;
                digit_held = 1'b0;
            end
            if (want_byte.size() > first_new)
            begin
                want_last[want_last.size() - 1] = 1'b1;
            end
        endfunction

        function void check_decoded(logic [7:0] got_byte, logic got_last);
            logic [7:0] exp_byte;
            bit         exp_last;
            bytes_out++;
            if (want_byte.size() == 0)
            begin
                note_failure($sformatf("unexpected decoded byte %02h last %0b",
                                       got_byte, got_last));
                return;
            end
            exp_byte = want_byte.pop_front();
            exp_last = want_last.pop_front();
            if (got_byte !== exp_byte || got_last !== exp_last)
            begin
                note_failure($sformatf("decoded byte %0d: expected %02h last %0b, got %02h last %0b",
                                       bytes_out, exp_byte, exp_last, got_byte, got_last));
            end
        endfunction

        function int unsigned outstanding();
            return want_byte.size();
        endfunction
    endclass

endpackage

### sim/escape_sequence_decoder_tb.sv
// ----------------------------------------------------------------------------
// escape_sequence_decoder_tb
// Self-checking testbench for the escape sequence decoder.
// ----------------------------------------------------------------------------
// A directed set covers plain bytes at both extremes, every escape letter,
// valid and invalid hex escapes, and every kind of end-of-stream flush. Random
// escape sequences with random content and random noise follow, under several
// idle and stall patterns and one long receiver hold-off that fills the
// decoder. Every output transaction is checked against the expected stream.
// ----------------------------------------------------------------------------
module escape_sequence_decoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import esd_pkg::*;
    import unescape_tb_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 200000;
    localparam int unsigned HOLD_OFF_CYCLES = 80;
    localparam int unsigned DRAIN_CYCLES    = 20;

    typedef struct {
        logic [7:0] value;
        logic       eos;
    } raw_item_t;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       push          = 1'b0;
    logic [7:0] in_byte       = '0;
    logic       end_of_stream = 1'b0;
    logic       pop           = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] out_byte;
    logic       last_of_run;

    raw_item_t       raw_stim[$];
    unescape_checker decoded_check;
    int unsigned     send_idle_pct  = 0;
    int unsigned     recv_stall_pct = 0;
    int unsigned     hold_request   = 0;
    int unsigned     cycle_count    = 0;
    int unsigned     full_cycles    = 0;

    escape_sequence_decoder i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .in_byte       (in_byte),
        .end_of_stream (end_of_stream),
        .empty         (empty),
        .pop           (pop),
        .out_byte      (out_byte),
        .last_of_run   (last_of_run)
    );

    always
    begin
        #5;
        clk = 1'b1;
        #5;
        clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timed out after %0d cycles.", cycle_count);
        $display("escape_sequence_decoder_tb: done, errors");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
            begin
                decoded_check.note_raw_byte(in_byte, end_of_stream);
            end
            if (push && full)
            begin
                full_cycles++;
            end
            if (pop && !empty)
            begin
                decoded_check.check_decoded(out_byte, last_of_run);
            end
        end
    end

    initial
    begin : receiver
        int unsigned hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    function automatic void add_byte(logic [7:0] value, logic eos);
        raw_item_t item;
        item.value = value;
        item.eos   = eos;
        raw_stim.push_back(item);
    endfunction

    function automatic void add_text(string s, logic eos_on_last);
        for (int i = 0; i < s.len(); i++)
        begin
            add_byte(s[i], eos_on_last && (i == s.len() - 1));
        end
    endfunction

    function automatic logic [7:0] pick_hex_digit();
        string hex_chars = "0123456789abcdefABCDEF";
        if ($urandom_range(0, 99) < 85)
        begin
            return hex_chars[$urandom_range(0, 21)];
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_escape_target();
        string letters = "0abtnfre";
        if ($urandom_range(0, 99) < 60)
        begin
            return letters[$urandom_range(0, 7)];
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void add_directed();
        add_byte(8'h00, 1'b0);
        add_text("\\0\\a\\b\\t\\n\\f\\r\\e", 1'b0);
        add_text("\\xFf", 1'b0);
        add_text("\\x+7", 1'b0);
        add_byte(8'hFF, 1'b1);
        add_text("\\", 1'b1);
        add_text("\\x", 1'b1);
        add_text("\\x7", 1'b1);
    endfunction

    function automatic void add_random_runs(int unsigned count);
        int unsigned target;
        int unsigned depth;
        target = raw_stim.size() + count;
        while (raw_stim.size() < target)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    add_byte(8'($urandom_range(0, 255)), 1'b0);
                end
                3, 4:
                begin
                    add_byte(CHAR_BACKSLASH, 1'b0);
                    add_byte(pick_escape_target(), $urandom_range(0, 19) == 0);
                end
                5, 6:
                begin
                    add_byte(CHAR_BACKSLASH, 1'b0);
                    add_byte(CHAR_X, 1'b0);
                    add_byte(pick_hex_digit(), 1'b0);
                    add_byte(pick_hex_digit(), $urandom_range(0, 19) == 0);
                end
                7:
                begin
                    depth = $urandom_range(0, 2);
                    add_byte(CHAR_BACKSLASH, depth == 0);
                    if (depth >= 1)
                    begin
                        add_byte(CHAR_X, depth == 1);
                    end
                    if (depth == 2)
                    begin
                        add_byte(pick_hex_digit(), 1'b1);
                    end
                end
                8:
                begin
                    add_byte(8'($urandom_range(0, 255)), 1'b1);
                end
                default:
                begin
                    add_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                end
            endcase
        end
    endfunction

    task automatic send_raw_bytes();
        raw_item_t item;
        while (raw_stim.size() > 0)
        begin
            item = raw_stim.pop_front();
            while ($urandom_range(0, 99) < send_idle_pct)
            begin
                push    <= 1'b0;
                in_byte <= 8'($urandom_range(0, 255));
                @(posedge clk);
            end
            push          <= 1'b1;
            in_byte       <= item.value;
            end_of_stream <= item.eos;
            @(posedge clk);
            while (full)
            begin
                @(posedge clk);
            end
        end
        push <= 1'b0;
    endtask

    task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct,
                             int unsigned count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        add_random_runs(count);
        send_raw_bytes();
    endtask

    initial
    begin
        decoded_check = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_directed();
        run_phase(0, 0, 45);
        run_phase(86, 0, 50);
        run_phase(0, 86, 50);
        run_phase(26, 26, 50);

        // Hold the output side off long enough for the input side to back up.
        hold_request = HOLD_OFF_CYCLES;
        run_phase(0, 0, 40);

        while (decoded_check.outstanding() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d raw bytes with %0d end-of-stream flushes of pending escapes;",
                 decoded_check.bytes_in, decoded_check.flushes);
        $display("checked %0d decoded bytes in %0d cycles, input held off for %0d cycles.",
                 decoded_check.bytes_out, cycle_count, full_cycles);
        if (decoded_check.mismatches == 0 && decoded_check.outstanding() == 0)
        begin
            $display("escape_sequence_decoder_tb: done, clean");
        end
        else
        begin
            $display("%0d mismatches, %0d decoded bytes never seen.",
                     decoded_check.mismatches, decoded_check.outstanding());
            $display("escape_sequence_decoder_tb: done, errors");
        end
        $finish;
    end

endmodule

### escape_sequence_decoder.f
rtl/core/esd_pkg.sv
rtl/core/esd_front.sv
rtl/core/esd_cmd_fifo.sv
rtl/core/esd_back.sv
rtl/core/escape_sequence_decoder.sv
sim/unescape_tb_pkg.sv
sim/escape_sequence_decoder_tb.sv
